// ===== design/dop4_pkg.sv =====
// ----------------------------------------------------------------------------
// dop4_pkg
// Shared types and constants for the 4-D dimension-order path generator.
// ----------------------------------------------------------------------------
package dop4_pkg;

  // node numbers and path positions
  localparam int unsigned NODE_W    = 11;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DIM_COUNT = 4;
  // remainders kept for R^1, R^2 and R^3
  localparam int unsigned REM_COUNT = DIM_COUNT - 1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [IDX_W-1:0]  hop_idx_t;

  // one path request
  typedef struct packed {
    node_t src_node;
    node_t dst_node;
  } request_t;

  // one path entry
  typedef struct packed {
    node_t    hop_node;
    hop_idx_t hop_index;
    logic     is_last;
  } hop_t;

  // source and destination split against the radix powers;
  // element m holds the node number modulo R^(m+1), x is the quotient by R^3
  typedef struct packed {
    node_t                   src_node;
    node_t                   dst_node;
    logic [REM_COUNT-1:0][NODE_W-1:0] src_rem;
    logic [REM_COUNT-1:0][NODE_W-1:0] dst_rem;
    node_t                   src_x;
    node_t                   dst_x;
  } split_t;

endpackage

// ===== design/dop4_split.sv =====
// ----------------------------------------------------------------------------
// dop4_split
// Two-stage divide by constant radix powers: a reciprocal estimate stage,
// then a constant multiply with one correction step.
// ----------------------------------------------------------------------------
module dop4_split
  import dop4_pkg::*;
#(
  parameter int unsigned DIM_RADIX = 6
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  request_t in_req,
  output logic     in_ready,
  output logic     out_valid,
  output split_t   out_split,
  input  logic     out_ready
);

  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = NODE_W + RECIP_SHIFT;
  localparam int unsigned POW [REM_COUNT] = '{DIM_RADIX, DIM_RADIX ** 2, DIM_RADIX ** 3};
  localparam int unsigned RECIP [REM_COUNT] = '{
    (1 << RECIP_SHIFT) / (DIM_RADIX),
    (1 << RECIP_SHIFT) / (DIM_RADIX ** 2),
    (1 << RECIP_SHIFT) / (DIM_RADIX ** 3)
  };
  localparam int unsigned POW_W  = $clog2(DIM_RADIX ** 3 + 1);
  localparam int unsigned QP_W   = NODE_W + POW_W;

  // stage a registers
  logic                              a_valid;
  request_t                          a_req;
  logic [REM_COUNT-1:0][NODE_W-1:0] a_src_q;
  logic [REM_COUNT-1:0][NODE_W-1:0] a_dst_q;

  logic [REM_COUNT-1:0][NODE_W-1:0] est_src_q;
  logic [REM_COUNT-1:0][NODE_W-1:0] est_dst_q;
  logic [REM_COUNT-1:0][PROD_W-1:0] prod_src;
  logic [REM_COUNT-1:0][PROD_W-1:0] prod_dst;

  logic [REM_COUNT-1:0][QP_W-1:0]   qp_src;
  logic [REM_COUNT-1:0][QP_W-1:0]   qp_dst;
  logic [REM_COUNT-1:0][NODE_W-1:0] raw_src_r;
  logic [REM_COUNT-1:0][NODE_W-1:0] raw_dst_r;
  logic [REM_COUNT-1:0][NODE_W-1:0] fix_src_r;
  logic [REM_COUNT-1:0][NODE_W-1:0] fix_dst_r;
  node_t                             fix_src_x;
  node_t                             fix_dst_x;

  logic a_ready;

  // elastic handshake between the two stages
  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  // quotient estimate, never above the true quotient and at most one below
  always_comb begin
    for (int m = 0; m < REM_COUNT; m++) begin
      prod_src[m]  = PROD_W'(in_req.src_node) * PROD_W'(RECIP[m]);
      prod_dst[m]  = PROD_W'(in_req.dst_node) * PROD_W'(RECIP[m]);
      est_src_q[m] = prod_src[m][PROD_W-1 -: NODE_W];
      est_dst_q[m] = prod_dst[m][PROD_W-1 -: NODE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_req   <= in_req;
      a_src_q <= est_src_q;
      a_dst_q <= est_dst_q;
    end
  end

  // remainder from the estimate, corrected by one subtract
  always_comb begin
    fix_src_x = a_src_q[REM_COUNT-1];
    fix_dst_x = a_dst_q[REM_COUNT-1];
    for (int m = 0; m < REM_COUNT; m++) begin
      qp_src[m]    = QP_W'(a_src_q[m]) * QP_W'(POW[m]);
      qp_dst[m]    = QP_W'(a_dst_q[m]) * QP_W'(POW[m]);
      raw_src_r[m] = a_req.src_node - qp_src[m][NODE_W-1:0];
      raw_dst_r[m] = a_req.dst_node - qp_dst[m][NODE_W-1:0];
      fix_src_r[m] = raw_src_r[m];
      fix_dst_r[m] = raw_dst_r[m];
      if (QP_W'(raw_src_r[m]) >= QP_W'(POW[m])) begin
        fix_src_r[m] = NODE_W'(raw_src_r[m] - NODE_W'(POW[m]));
        if (m == REM_COUNT - 1) begin
          fix_src_x = NODE_W'(a_src_q[m] + 1'b1);
        end
      end
      if (QP_W'(raw_dst_r[m]) >= QP_W'(POW[m])) begin
        fix_dst_r[m] = NODE_W'(raw_dst_r[m] - NODE_W'(POW[m]));
        if (m == REM_COUNT - 1) begin
          fix_dst_x = NODE_W'(a_dst_q[m] + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid) begin
      out_split.src_node <= a_req.src_node;
      out_split.dst_node <= a_req.dst_node;
      out_split.src_rem  <= fix_src_r;
      out_split.dst_rem  <= fix_dst_r;
      out_split.src_x    <= fix_src_x;
      out_split.dst_x    <= fix_dst_x;
    end
  end

endmodule

// ===== design/dop4_emit.sv =====
// ----------------------------------------------------------------------------
// dop4_emit
// Builds the hop list from a split request and sends one path entry per
// cycle through the result register, X first and W last.
// ----------------------------------------------------------------------------
module dop4_emit
  import dop4_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  split_t in_split,
  output logic   in_ready,
  output logic   hop_valid,
  output hop_t   hop
);

  // hops still to send and their node numbers
  logic [DIM_COUNT-1:0]             pend;
  logic [DIM_COUNT-1:0][NODE_W-1:0] nodes;

  logic [DIM_COUNT-1:0]             diff;
  logic [DIM_COUNT-1:0][NODE_W-1:0] node_c;
  logic [$clog2(DIM_COUNT)-1:0]     pick;
  logic                             found;
  logic [DIM_COUNT-1:0]             pend_next;
  logic                             load;

  assign in_ready = (pend == '0);
  assign load     = in_ready && in_valid;

  // differing digits and the node reached after fixing each dimension
  always_comb begin
    diff[0] = (in_split.src_x != in_split.dst_x);
    for (int k = 1; k < DIM_COUNT; k++) begin
      if (k == DIM_COUNT - 1) begin
        diff[k] = (in_split.src_rem[0] != in_split.dst_rem[0]);
      end else begin
        diff[k] = (NODE_W'(in_split.src_rem[DIM_COUNT-1-k] - in_split.src_rem[DIM_COUNT-2-k]) !=
                   NODE_W'(in_split.dst_rem[DIM_COUNT-1-k] - in_split.dst_rem[DIM_COUNT-2-k]));
      end
    end
    for (int k = 0; k < DIM_COUNT - 1; k++) begin
      node_c[k] = NODE_W'(in_split.dst_node - in_split.dst_rem[DIM_COUNT-2-k] +
                          in_split.src_rem[DIM_COUNT-2-k]);
    end
    node_c[DIM_COUNT-1] = in_split.dst_node;
  end

  // lowest pending dimension goes next
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int k = 0; k < DIM_COUNT; k++) begin
      if (pend[k] && !found) begin
        pick  = ($clog2(DIM_COUNT))'(k);
        found = 1'b1;
      end
    end
    pend_next = pend & ~(DIM_COUNT'(1) << pick);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      hop_valid <= 1'b0;
    end else if (pend != '0) begin
      pend      <= pend_next;
      hop_valid <= 1'b1;
    end else if (in_valid) begin
      pend      <= diff;
      hop_valid <= 1'b1;
    end else begin
      hop_valid <= 1'b0;
    end
  end

  // result register and hop node store
  always_ff @(posedge clk) begin
    if (pend != '0) begin
      hop.hop_node  <= nodes[pick];
      hop.hop_index <= IDX_W'(hop.hop_index + 1'b1);
      hop.is_last   <= (pend_next == '0);
    end else if (load) begin
      hop.hop_node  <= in_split.src_node;
      hop.hop_index <= '0;
      hop.is_last   <= (diff == '0);
      nodes         <= node_c;
    end
  end

  // hops left over means the entry just sent was not the last one
  a_pend_not_last: assert property (@(posedge clk) disable iff (rst)
    (pend != '0) |-> (hop_valid && !hop.is_last))
    else $error("pending hops after a final entry");

  // path positions count up by one within a path
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (hop_valid && !hop.is_last) |=> (hop_valid &&
      hop.hop_index == IDX_W'($past(hop.hop_index) + 1'b1)))
    else $error("path position did not advance");

  // a path never has more entries than dimensions plus the source
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    hop_valid |-> (hop.hop_index <= IDX_W'(DIM_COUNT)))
    else $error("path position out of range");

  // a new request loads only once the previous path is finished
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    (in_valid && pend == '0) |=> (hop_valid && hop.hop_index == '0))
    else $error("new path did not start at the source");

endmodule

// ===== design/dimension_order_path_4d.sv =====
// ----------------------------------------------------------------------------
// dimension_order_path_4d
// Dimension-order path generator for a 4-D fully connected network.
// ----------------------------------------------------------------------------
// Usage:
//   A request (source and destination node) transfers at a rising edge where
//   start is high and busy is low. The block answers with the path: the
//   source first, then one entry for each dimension whose digit differs, in
//   X, Y, Z, W order, each on hop for exactly one cycle with hop_valid high.
//   The final entry, the destination, has is_last set.
// Path: a request passes the input register, the reciprocal estimate
//   stage and the remainder correction stage, then the result register
//   shows the source entry. Throughput: one entry per cycle; a request
//   occupies the result register until its final entry has been shown.
//   Requests are taken back to back while an earlier path is still going
//   out; busy rises only once the three front stages are all holding work.
// Reset: rst clears all valid flags and pending hops; no path is sent until
//   a new request is taken.
// The receiver cannot stall: each entry is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module dimension_order_path_4d
  import dop4_pkg::*;
#(
  parameter int unsigned DIM_RADIX = 6
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     hop_valid,
  output hop_t     hop
);

  logic     in_valid;
  request_t in_req;
  logic     split_in_ready;
  logic     split_valid;
  split_t   split;
  logic     emit_ready;

  assign busy = in_valid && !split_in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (start && !busy) begin
      in_valid <= 1'b1;
    end else if (split_in_ready) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= request;
    end
  end

  // digit split
  dop4_split #(
    .DIM_RADIX (DIM_RADIX)
  ) u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_ready  (split_in_ready),
    .out_valid (split_valid),
    .out_split (split),
    .out_ready (emit_ready)
  );

  // hop sequencing and result register
  dop4_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_split  (split),
    .in_ready  (emit_ready),
    .hop_valid (hop_valid),
    .hop       (hop)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the 4-D dimension-order path generator. Requests are sent with
// random gaps: a directed set of corner cases first, then random source and
// destination pairs, most differing in a chosen set of digits. A predictor works
// out each path, and every hop is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import dop4_pkg::*;

  localparam int unsigned RADIX      = 6;
  localparam int unsigned RAND_ITEMS = 190;
  localparam int unsigned DRAIN_CYC  = 16;
  localparam int unsigned CYCLE_MAX  = 200000;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     hop_valid;
  hop_t     hop;

  request_t    req_queue [$];
  hop_t        path_exp [$];
  hop_t        exp_hop;
  int unsigned accepted_cnt = 0;
  int unsigned idle_pct     = 19;
  int unsigned error_cnt    = 0;
  int unsigned cycle_cnt    = 0;

  dimension_order_path_4d #(
    .DIM_RADIX (RADIX)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .hop_valid (hop_valid),
    .hop       (hop)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_cnt++;
  endtask

  // append one request to the pending list
  task automatic queue_req(input request_t r);
    req_queue = {req_queue, r};
  endtask

  // recombine four base-radix digits, truncated to the node width
  function automatic node_t join_node(input int unsigned dig [4]);
    int unsigned n;
    n = ((dig[0] * RADIX + dig[1]) * RADIX + dig[2]) * RADIX + dig[3];
    return node_t'(n);
  endfunction

  // work out the full path for one request and queue its hops
  task automatic route_path(input request_t req);
    int unsigned cur [4];
    int unsigned goal [4];
    int unsigned ns;
    int unsigned nd;
    hop_t        hops [5];
    int          cnt;
    ns = 32'(req.src_node);
    nd = 32'(req.dst_node);
    // w, z, y are low digits; x keeps the remaining quotient
    for (int k = 3; k >= 1; k--) begin
      cur[k]  = ns % RADIX;
      goal[k] = nd % RADIX;
      ns = ns / RADIX;
      nd = nd / RADIX;
    end
    cur[0]  = ns;
    goal[0] = nd;
    hops[0] = '{hop_node: req.src_node, hop_index: '0, is_last: 1'b0};
    cnt = 1;
    for (int k = 0; k < 4; k++) begin
      if (cur[k] != goal[k]) begin
        cur[k] = goal[k];
        hops[cnt] = '{hop_node: join_node(cur), hop_index: hop_idx_t'(cnt), is_last: 1'b0};
        cnt++;
      end
    end
    hops[cnt-1].is_last = 1'b1;
    for (int k = 0; k < cnt; k++)
      path_exp = {path_exp, hops[k]};
  endtask

  // random pair: source digits, destination differs in a random digit set
  function automatic request_t shaped_request();
    int unsigned s [4];
    int unsigned d [4];
    int unsigned mask;
    request_t    r;
    mask = $urandom_range(0, 15);
    for (int k = 0; k < 4; k++) begin
      s[k] = $urandom_range(0, RADIX - 1);
      d[k] = mask[k] ? (s[k] + 1 + $urandom_range(0, RADIX - 2)) % RADIX : s[k];
    end
    r.src_node = join_node(s);
    r.dst_node = join_node(d);
    return r;
  endfunction

  // driver: when the slot is free, offer the next request or leave a random gap
  always @(posedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      request <= '0;
    end else begin
      if (start && !busy) begin
        route_path(request);
        accepted_cnt++;
      end
      if (!start || !busy) begin
        idle_pct = (accepted_cnt >= 90 && accepted_cnt < 150) ? 0 : 19;
        if (req_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          request <= req_queue.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each hop transfer is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && hop_valid) begin
      if (path_exp.size() == 0) begin
        flag_mismatch($sformatf("unexpected hop node=%0d idx=%0d last=%0d",
                                hop.hop_node, hop.hop_index, hop.is_last));
      end else begin
        exp_hop = path_exp.pop_front();
        if (hop.hop_node !== exp_hop.hop_node)
          flag_mismatch($sformatf("hop_node got %0d want %0d", hop.hop_node,
                                  exp_hop.hop_node));
        if (hop.hop_index !== exp_hop.hop_index)
          flag_mismatch($sformatf("hop_index got %0d want %0d", hop.hop_index,
                                  exp_hop.hop_index));
        if (hop.is_last !== exp_hop.is_last)
          flag_mismatch($sformatf("is_last got %0d want %0d", hop.is_last,
                                  exp_hop.is_last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_MAX) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    request_t r;
    rst = 1'b1;

    // equal nodes, extremes and nodes beyond the network
    queue_req('{src_node: 11'd0,    dst_node: 11'd0});
    queue_req('{src_node: 11'd1295, dst_node: 11'd1295});
    queue_req('{src_node: 11'd0,    dst_node: 11'd1295});
    queue_req('{src_node: 11'd1295, dst_node: 11'd0});
    queue_req('{src_node: 11'd2047, dst_node: 11'd2047});
    queue_req('{src_node: 11'd2047, dst_node: 11'd0});
    queue_req('{src_node: 11'd0,    dst_node: 11'd2047});
    queue_req('{src_node: 11'd1296, dst_node: 11'd5});
    queue_req('{src_node: 11'd1500, dst_node: 11'd1501});
    queue_req('{src_node: 11'd1024, dst_node: 11'd1023});
    // a single differing digit in each dimension
    queue_req('{src_node: 11'd0,    dst_node: 11'd216});
    queue_req('{src_node: 11'd0,    dst_node: 11'd36});
    queue_req('{src_node: 11'd0,    dst_node: 11'd6});
    queue_req('{src_node: 11'd0,    dst_node: 11'd1});
    queue_req('{src_node: 11'd1295, dst_node: 11'd1295 - 11'd216});
    queue_req('{src_node: 11'd1295, dst_node: 11'd1295 - 11'd1});
    // all digits or all but one digit differ
    queue_req('{src_node: 11'd259,  dst_node: 11'd1036});
    queue_req('{src_node: 11'd1365, dst_node: 11'd682});
    queue_req('{src_node: 11'd682,  dst_node: 11'd1365});
    queue_req('{src_node: 11'd2046, dst_node: 11'd1});

    // random part: mostly shaped pairs, some raw 11-bit noise
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        r = shaped_request();
      end else begin
        r.src_node = node_t'($urandom);
        r.dst_node = ($urandom_range(0, 3) == 0) ? r.src_node : node_t'($urandom);
      end
      queue_req(r);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait until every request has transferred and every hop has come
    @(negedge clk);
    while (req_queue.size() > 0 || start || path_exp.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    if (path_exp.size() > 0)
      flag_mismatch($sformatf("%0d hops never arrived", path_exp.size()));

    if (error_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
